@@ hw/rtl/rtks_pkg.sv @@
package rtks_pkg;

	localparam int unsigned VALUE_W   = 32;
	localparam int unsigned ID_W      = 16;
	localparam int unsigned TOTAL_W   = 37;
	localparam int unsigned TAKE_W    = 5;
	localparam int unsigned K_MAX_DEF = 16;

	localparam int unsigned IN_DATA_W  = ((VALUE_W + ID_W + 7) / 8) * 8;
	localparam int unsigned OUT_DATA_W = ((ID_W + TOTAL_W + 7) / 8) * 8;

endpackage

@@ hw/rtl/rtks_list.sv @@
module rtks_list #(
	parameter int unsigned K_MAX = rtks_pkg::K_MAX_DEF,
	localparam int unsigned NW = $clog2(K_MAX + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          upd,
	input  logic                          clr,
	input  logic [rtks_pkg::VALUE_W-1:0]  v,
	input  logic [NW-1:0]                 n,
	output logic [rtks_pkg::TOTAL_W-1:0]  total
);

	localparam int unsigned IW = (K_MAX > 1) ? $clog2(K_MAX) : 1;

	// Cell i holds the i-th largest value; psum_q[i] holds the sum of cells 0 to i.
	logic [rtks_pkg::VALUE_W-1:0] top_q  [K_MAX];
	logic [rtks_pkg::TOTAL_W-1:0] psum_q [K_MAX];

	logic [rtks_pkg::VALUE_W-1:0] cur_top [K_MAX];
	logic [rtks_pkg::TOTAL_W-1:0] cur_ps  [K_MAX];
	logic [rtks_pkg::VALUE_W-1:0] nxt_top [K_MAX];
	logic [rtks_pkg::TOTAL_W-1:0] nxt_ps  [K_MAX];
	logic [K_MAX-1:0]             geq;
	logic [rtks_pkg::TOTAL_W-1:0] v_ext;
	logic [rtks_pkg::TOTAL_W-1:0] sel_sum;
	logic [IW-1:0]                idx;

	assign v_ext = rtks_pkg::TOTAL_W'(v);

	genvar i;
	generate
		for (i = 0; i < K_MAX; i++) begin : g_cell
			assign cur_top[i] = clr ? '0 : top_q[i];
			assign cur_ps[i]  = clr ? '0 : psum_q[i];
			assign geq[i]     = (cur_top[i] >= v);
			if (i == 0) begin : g_first
				assign nxt_top[i] = geq[i] ? cur_top[i] : v;
				assign nxt_ps[i]  = geq[i] ? cur_ps[i] : v_ext;
			end else begin : g_rest
				assign nxt_top[i] = geq[i]   ? cur_top[i] :
				                    geq[i-1] ? v : cur_top[i-1];
				assign nxt_ps[i]  = geq[i] ? cur_ps[i] : cur_ps[i-1] + v_ext;
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					top_q[i]  <= '0;
					psum_q[i] <= '0;
				end else if (upd) begin
					top_q[i]  <= nxt_top[i];
					psum_q[i] <= nxt_ps[i];
				end
			end
		end
	endgenerate

	assign idx     = IW'(n - NW'(1));
	assign sel_sum = (n == '0) ? '0 : cur_ps[idx];
	assign total   = v_ext + sel_sum;

endmodule

@@ hw/rtl/running_top_k_sum.sv @@
// Each beat passes from the input register to the result register once the result
// register is empty or being read, so back-pressure on m_tready can hold it between.
// Throughput: one beat per cycle unless m_tready stalls the output; the sorted
// list and its prefix sums update in the same cycle an item moves from the
// input register to the result register. Reset clears the list to zero, sets
// take_count to zero and empties both registers.
module running_top_k_sum #(
	parameter int unsigned K_MAX = rtks_pkg::K_MAX_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [rtks_pkg::TAKE_W-1:0]      cfg_wdata,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// item_value, item_id
	input  logic [rtks_pkg::IN_DATA_W-1:0]   s_tdata,
	// start_req
	input  logic                             s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// result_id, total, zero fill
	output logic [rtks_pkg::OUT_DATA_W-1:0]  m_tdata
);

	localparam int unsigned NW = $clog2(K_MAX + 1);
	localparam int unsigned CW = (NW > rtks_pkg::TAKE_W) ? NW : rtks_pkg::TAKE_W;

	logic [rtks_pkg::TAKE_W-1:0]  take_count_q;
	logic                         vld_s1;
	logic                         start_s1;
	logic [rtks_pkg::VALUE_W-1:0] value_s1;
	logic [rtks_pkg::ID_W-1:0]    id_s1;
	logic [rtks_pkg::ID_W-1:0]    id_q;
	logic [rtks_pkg::TOTAL_W-1:0] total_q;
	logic                         adv;
	logic [CW-1:0]                tc_ext;
	logic [CW-1:0]                kmax_c;
	logic [NW-1:0]                n;
	logic [rtks_pkg::TOTAL_W-1:0] total;

	assign adv      = vld_s1 && (!m_tvalid || m_tready);
	assign s_tready = !vld_s1 || adv;

	assign tc_ext = CW'(take_count_q);
	assign kmax_c = CW'(K_MAX);
	assign n      = (tc_ext > kmax_c) ? kmax_c[NW-1:0] : tc_ext[NW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			take_count_q <= '0;
		end else if (cfg_we) begin
			take_count_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (s_tready) begin
				vld_s1 <= s_tvalid;
			end
			if (adv) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			start_s1 <= s_tuser;
			value_s1 <= s_tdata[rtks_pkg::VALUE_W-1:0];
			id_s1    <= s_tdata[rtks_pkg::VALUE_W +: rtks_pkg::ID_W];
		end
		if (adv) begin
			id_q    <= id_s1;
			total_q <= total;
		end
	end

	rtks_list #(
		.K_MAX (K_MAX)
	) u_list (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (adv),
		.clr    (start_s1),
		.v      (value_s1),
		.n      (n),
		.total  (total)
	);

	assign m_tdata = rtks_pkg::OUT_DATA_W'({total_q, id_q});

endmodule
